// ===== sv/sensor_word_crc_frame_checker_assert.svh =====
// Assertion macros used by the frame checker FIFO.
`ifndef SENSOR_WORD_CRC_FRAME_CHECKER_ASSERT_SVH
`define SENSOR_WORD_CRC_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame checker assertion failed");

// Next-cycle implication, checked outside reset.
`define SCFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame checker assertion failed");

`endif

// ===== sv/scfc_pkg.sv =====
// Types and constants shared by the sensor frame checker.
package scfc_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_CRC_POLY  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_FIRST = 1'b1;

    localparam logic [7:0] CRC_POLY_RESET = 8'h31;
    localparam logic [7:0] CRC_INIT       = 8'hFF;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    typedef struct packed {
        logic [15:0] temperature_raw;
        logic [15:0] humidity_raw;
        logic        temperature_crc_ok;
        logic        humidity_crc_ok;
    } scfc_frame_t;

endpackage

// ===== sv/scfc_ifs.sv =====
// Handshake interfaces for the byte, result and configuration channels.
interface scfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface scfc_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        temperature_raw;
    logic [15:0]        humidity_raw;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               temperature_crc_ok;
    logic               humidity_crc_ok;

    modport source (output valid, output temperature_raw, output humidity_raw,
                    output temperature_centi, output humidity_centi,
                    output temperature_crc_ok, output humidity_crc_ok, input ready);
    modport sink   (input valid, input temperature_raw, input humidity_raw,
                    input temperature_centi, input humidity_centi,
                    input temperature_crc_ok, input humidity_crc_ok, output ready);
endinterface

interface scfc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [scfc_pkg::CFG_ADDR_W-1:0] addr;
    logic [scfc_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== sv/scfc_front.sv =====
// Front end: byte framing, per-word CRC check and frame assembly.
module scfc_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    scfc_in_if.sink               rx,
    scfc_cfg_if.sink              cfg,
    input  logic                  fifo_full,
    output logic                  push,
    output scfc_pkg::scfc_frame_t push_data
);
    import scfc_pkg::*;

    localparam logic [2:0] POS_FIRST_CHECK = 3'd2;
    localparam logic [2:0] POS_LAST        = 3'd5;

    logic [7:0]  poly_reg;
    logic        hum_first_reg;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] partial_reg, partial_next;
    logic [15:0] first_reg, first_next;
    logic        first_ok_reg, first_ok_next;

    logic        accept;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_base;
    logic [7:0]  crc_folded;
    logic        crc_match;

    function automatic logic [7:0] crc_fold(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    assign cfg.ready = 1'b1;
    assign rx.ready  = !fifo_full;
    assign accept    = rx.valid && rx.ready;

    always_comb
    begin
        pos_eff    = (rx.frame_start || pos_reg > POS_LAST) ? 3'd0 : pos_reg;
        crc_base   = (pos_eff inside {3'd0, 3'd3}) ? CRC_INIT : crc_reg;
        crc_folded = crc_fold(crc_base, rx.rx_byte, poly_reg);
        crc_match  = (crc_reg == rx.rx_byte);

        pos_next      = pos_reg;
        crc_next      = crc_reg;
        partial_next  = partial_reg;
        first_next    = first_reg;
        first_ok_next = first_ok_reg;

        if (accept)
        begin
            if (pos_eff inside {3'd0, 3'd3})
            begin
                crc_next     = crc_folded;
                partial_next = {rx.rx_byte, 8'h00};
                pos_next     = pos_eff + 3'd1;
            end
            else if (pos_eff inside {3'd1, 3'd4})
            begin
                crc_next     = crc_folded;
                partial_next = partial_reg | {8'h00, rx.rx_byte};
                pos_next     = pos_eff + 3'd1;
            end
            else if (pos_eff == POS_FIRST_CHECK)
            begin
                crc_next      = CRC_INIT;
                first_next    = partial_reg;
                first_ok_next = crc_match;
                pos_next      = pos_eff + 3'd1;
            end
            else
            begin
                crc_next = CRC_INIT;
                pos_next = 3'd0;
            end
        end
    end

    // The last byte of a frame hands both words to the queue in output order.
    always_comb
    begin
        push = accept && (pos_eff == POS_LAST);
        if (hum_first_reg)
        begin
            push_data.humidity_raw       = first_reg;
            push_data.humidity_crc_ok    = first_ok_reg;
            push_data.temperature_raw    = partial_reg;
            push_data.temperature_crc_ok = crc_match;
        end
        else
        begin
            push_data.temperature_raw    = first_reg;
            push_data.temperature_crc_ok = first_ok_reg;
            push_data.humidity_raw       = partial_reg;
            push_data.humidity_crc_ok    = crc_match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= CRC_POLY_RESET;
            hum_first_reg <= 1'b0;
            pos_reg       <= 3'd0;
            crc_reg       <= CRC_INIT;
            first_ok_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    REG_CRC_POLY:  poly_reg      <= cfg.wdata;
                    REG_HUM_FIRST: hum_first_reg <= cfg.wdata[0];
                    default:       ;
                endcase
            end
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            first_ok_reg <= first_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        partial_reg <= partial_next;
        first_reg   <= first_next;
    end

endmodule

// ===== sv/scfc_fifo.sv =====
// Short frame queue between the front end and the conversion back end.
`include "sensor_word_crc_frame_checker_assert.svh"

module scfc_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  scfc_pkg::scfc_frame_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  valid,
    output scfc_pkg::scfc_frame_t head
);
    import scfc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    scfc_frame_t       mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_FULL);
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `SCFC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `SCFC_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full)
    `SCFC_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, valid)
    `SCFC_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// ===== sv/scfc_back.sv =====
// Back end: fixed-point conversion of both words and the result register.
module scfc_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fifo_valid,
    input  scfc_pkg::scfc_frame_t fifo_head,
    output logic                  pop,
    scfc_out_if.source            res
);
    import scfc_pkg::*;

    // Product stage.
    logic        prod_valid_reg;
    scfc_frame_t prod_frame_reg;
    logic [30:0] temp_prod_reg, temp_prod_next;
    logic [29:0] hum_prod_reg, hum_prod_next;

    // Result stage.
    logic               res_valid_reg;
    scfc_frame_t        res_frame_reg;
    logic signed [14:0] temp_centi_reg, temp_centi_next;
    logic [13:0]        hum_centi_reg, hum_centi_next;

    logic res_load;
    logic prod_load;

    assign res_load  = prod_valid_reg && (!res_valid_reg || res.ready);
    assign prod_load = !prod_valid_reg || res_load;
    assign pop       = fifo_valid && prod_load;

    always_comb
    begin
        temp_prod_next  = 31'(fifo_head.temperature_raw) * 31'(TEMP_SCALE);
        hum_prod_next   = 30'(fifo_head.humidity_raw) * 30'(HUM_SCALE);
        temp_centi_next = signed'(temp_prod_reg[30:16] - TEMP_OFFSET);
        hum_centi_next  = hum_prod_reg[29:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_load)
            begin
                prod_valid_reg <= fifo_valid;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_frame_reg <= fifo_head;
            temp_prod_reg  <= temp_prod_next;
            hum_prod_reg   <= hum_prod_next;
        end
        if (res_load)
        begin
            res_frame_reg  <= prod_frame_reg;
            temp_centi_reg <= temp_centi_next;
            hum_centi_reg  <= hum_centi_next;
        end
    end

    assign res.valid              = res_valid_reg;
    assign res.temperature_raw    = res_frame_reg.temperature_raw;
    assign res.humidity_raw       = res_frame_reg.humidity_raw;
    assign res.temperature_crc_ok = res_frame_reg.temperature_crc_ok;
    assign res.humidity_crc_ok    = res_frame_reg.humidity_crc_ok;
    assign res.temperature_centi  = temp_centi_reg;
    assign res.humidity_centi     = hum_centi_reg;

endmodule

// ===== sv/sensor_word_crc_frame_checker.sv =====
// Top level of the six-byte sensor frame checker.
//
//  channel | direction | carries
//  rx      | in        | rx_byte, frame_start (one frame byte per request)
//  res     | out       | raw words, converted values, CRC flags (one per frame)
//  cfg     | in        | addr, wdata (crc_polynomial, humidity_first)
//
// One byte is taken per cycle while the queue is not full; the per-byte CRC fold is combinational.
// A frame result passes from its sixth byte through the queue, then the
// multiplier stage, then the result register.
// Reset clears all control state at once; there is no clearing pass.
// A stalled result fills the queue; rx stalls only when the queue is full.
module sensor_word_crc_frame_checker
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    scfc_in_if.sink    rx,
    scfc_out_if.source res,
    scfc_cfg_if.sink   cfg
);
    import scfc_pkg::*;

    logic        fifo_full;
    logic        fifo_push;
    scfc_frame_t fifo_push_data;
    logic        fifo_pop;
    logic        fifo_valid;
    scfc_frame_t fifo_head;

    scfc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .fifo_full (fifo_full),
        .push      (fifo_push),
        .push_data (fifo_push_data)
    );

    scfc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_push_data),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .valid     (fifo_valid),
        .head      (fifo_head)
    );

    scfc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_valid (fifo_valid),
        .fifo_head  (fifo_head),
        .pop        (fifo_pop),
        .res        (res)
    );

endmodule

// ===== dv/scfc_frame_math_pkg.sv =====
`timescale 1ns / 100ps
// CRC and unit conversion arithmetic used by the frame checker testbench.
package scfc_frame_math_pkg;

    import scfc_pkg::*;

    // One byte folded into the CRC, MSB first.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        int i;
        c = crc ^ data;
        for (i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] crc8_word(input logic [15:0] w, input logic [7:0] poly);
        return crc8_fold(crc8_fold(CRC_INIT, w[15:8], poly), w[7:0], poly);
    endfunction

    function automatic logic signed [14:0] temp_to_centi(input logic [15:0] raw);
        logic [31:0] prod;
        int v;
        prod = 32'(TEMP_SCALE) * 32'(raw);
        v = int'(prod >> 16) - int'(TEMP_OFFSET);
        return v[14:0];
    endfunction

    function automatic logic [13:0] hum_to_centi(input logic [15:0] raw);
        logic [31:0] prod;
        prod = 32'(HUM_SCALE) * 32'(raw);
        return prod[29:16];
    endfunction

endpackage

// ===== dv/scfc_frame_monitor.sv =====
`timescale 1ns / 100ps
// Channel monitor that predicts each frame result of the checker and compares it.
module scfc_frame_monitor
(
    input  logic clk,
    input  logic rst_n,
    scfc_in_if   rx,
    scfc_out_if  res,
    scfc_cfg_if  cfg,
    output int   mismatches,
    output int   frames_pending
);
    import scfc_pkg::*;
    import scfc_frame_math_pkg::*;

    typedef struct {
        logic [15:0]        temp_word;
        logic [15:0]        hum_raw;
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
        logic               temp_ok;
        logic               hum_ok;
    } frame_result_t;

    frame_result_t frames_due[$];

    logic [7:0]  poly;
    logic        hum_first;
    logic [2:0]  byte_pos;
    logic [7:0]  crc_acc;
    logic [15:0] word_acc;
    logic [15:0] word0;
    logic        word0_ok;
    int          errs = 0;

    assign mismatches = errs;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errs++;
    endtask

    task automatic compare_field(input string field, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic start);
        logic [2:0]    p;
        logic          ok;
        frame_result_t fr;
        p = (start || byte_pos >= 3'd6) ? 3'd0 : byte_pos;
        case (p)
            3'd0, 3'd3:
            begin
                crc_acc  = crc8_fold(CRC_INIT, b, poly);
                word_acc = {b, 8'h00};
                byte_pos = p + 3'd1;
            end
            3'd1, 3'd4:
            begin
                crc_acc       = crc8_fold(crc_acc, b, poly);
                word_acc[7:0] = b;
                byte_pos      = p + 3'd1;
            end
            default:
            begin
                ok      = (crc_acc == b);
                crc_acc = CRC_INIT;
                if (p == 3'd2)
                begin
                    word0    = word_acc;
                    word0_ok = ok;
                    byte_pos = 3'd3;
                end
                else
                begin
                    byte_pos = 3'd0;
                    if (hum_first)
                    begin
                        fr.hum_raw   = word0;
                        fr.hum_ok    = word0_ok;
                        fr.temp_word = word_acc;
                        fr.temp_ok   = ok;
                    end
                    else
                    begin
                        fr.temp_word = word0;
                        fr.temp_ok   = word0_ok;
                        fr.hum_raw   = word_acc;
                        fr.hum_ok    = ok;
                    end
                    fr.temp_centi = temp_to_centi(fr.temp_word);
                    fr.hum_centi  = hum_to_centi(fr.hum_raw);
                    frames_due.push_back(fr);
                end
            end
        endcase
    endtask

    task automatic check_result();
        frame_result_t want;
        if (frames_due.size() == 0)
        begin
            report_mismatch($sformatf("result with no frame pending, temperature_raw %0h",
                                      res.temperature_raw));
        end
        else
        begin
            want = frames_due.pop_front();
            compare_field("temperature_raw", res.temperature_raw, want.temp_word);
            compare_field("humidity_raw", res.humidity_raw, want.hum_raw);
            compare_field("temperature_centi", res.temperature_centi, want.temp_centi);
            compare_field("humidity_centi", res.humidity_centi, want.hum_centi);
            compare_field("temperature_crc_ok", res.temperature_crc_ok, want.temp_ok);
            compare_field("humidity_crc_ok", res.humidity_crc_ok, want.hum_ok);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly      = CRC_POLY_RESET;
            hum_first = 1'b0;
            byte_pos  = 3'd0;
            crc_acc   = CRC_INIT;
            word_acc  = 16'h0000;
            word0     = 16'h0000;
            word0_ok  = 1'b0;
            frames_due.delete();
            frames_pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    REG_CRC_POLY:  poly = cfg.wdata;
                    REG_HUM_FIRST: hum_first = cfg.wdata[0];
                    default: ;
                endcase
            end
            // A result accepted now always belongs to an earlier byte.
            if (res.valid && res.ready)
            begin
                check_result();
            end
            if (rx.valid && rx.ready)
            begin
                absorb_byte(rx.rx_byte, rx.frame_start);
            end
            frames_pending <= frames_due.size();
        end
    end

endmodule

// ===== dv/tb_sensor_word_crc_frame_checker.sv =====
`timescale 1ns / 100ps
// Top of the frame checker testbench: clock, reset, byte and register stimulus, verdict.
module tb_sensor_word_crc_frame_checker;

    import scfc_pkg::*;
    import scfc_frame_math_pkg::*;

    localparam int ITEM_TARGET   = 1750;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_SETTINGS  = 9;

    localparam logic [7:0] POLY_SET [NUM_SETTINGS] =
        '{8'h31, 8'h00, 8'hFF, 8'h07, 8'h9B, 8'h80, 8'h01, 8'h31, 8'hD5};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    int   mismatches;
    int   frames_pending;
    int   items_sent    = 0;
    int   quiet_cycles  = 0;
    bit   aligned       = 1'b1;
    logic [7:0] cur_poly = CRC_POLY_RESET;

    scfc_in_if  rx_ch ();
    scfc_out_if res_ch ();
    scfc_cfg_if cfg_ch ();

    sensor_word_crc_frame_checker dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    scfc_frame_monitor mon
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx_ch),
        .res            (res_ch),
        .cfg            (cfg_ch),
        .mismatches     (mismatches),
        .frames_pending (frames_pending)
    );

    always #2 clk = ~clk;

    // Ends the run when no request of any channel completes for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver; a hold request keeps ready low long enough to back up the input.
    initial
    begin
        int i;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                for (i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(posedge clk);
                end
                hold_req = 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Valid stays high after a request until an idle pause or rx_release lowers it.
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_start <= start;
        @(posedge clk);
        while (!rx_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic rx_release();
        rx_ch.valid <= 1'b0;
    endtask

    task automatic send_word(input logic [15:0] w, input bit good, input logic start);
        logic [7:0] check_byte;
        check_byte = crc8_word(w, cur_poly);
        if (!good)
        begin
            check_byte = check_byte ^ 8'($urandom_range(1, 255));
        end
        send_byte(w[15:8], start);
        send_byte(w[7:0], 1'b0);
        send_byte(check_byte, 1'b0);
    endtask

    task automatic send_frame(input logic [15:0] w0, input bit good0,
                              input logic [15:0] w1, input bit good1, input logic start);
        send_word(w0, good0, start);
        send_word(w1, good1, 1'b0);
        aligned = 1'b1;
    endtask

    function automatic logic [15:0] rand_word();
        int r;
        r = $urandom_range(7);
        if (r == 0)
        begin
            return 16'h0000;
        end
        if (r == 1)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    task automatic drain();
        @(posedge clk);
        while (frames_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.wdata <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        if (addr == REG_CRC_POLY)
        begin
            cur_poly = data;
        end
    endtask

    task automatic apply_setting(input logic [7:0] poly, input logic hum_first);
        drain();
        write_reg(REG_CRC_POLY, poly);
        write_reg(REG_HUM_FIRST, {7'b0, hum_first});
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random words; the rest are broken frames.
    task automatic random_sequence();
        int n;
        int i;
        logic start;
        if ($urandom_range(99) < 85)
        begin
            start = (aligned && $urandom_range(1) == 0) ? 1'b0 : 1'b1;
            send_frame(rand_word(), $urandom_range(99) < 85,
                       rand_word(), $urandom_range(99) < 85, start);
        end
        else
        begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
            begin
                send_byte(8'($urandom), 1'($urandom_range(1)));
            end
            aligned = 1'b0;
        end
    endtask

    initial
    begin
        int mode;
        int sub;
        int idx;
        logic [7:0] poly;

        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = 8'h00;
        rx_ch.frame_start = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.addr       = REG_CRC_POLY;
        cfg_ch.wdata      = 8'h00;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset settings: word extremes, a bad checksum
        // in each word, a frame with no start mark and a start mark mid-frame.
        send_frame(16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b1);
        send_frame(16'hFFFF, 1'b0, 16'h0000, 1'b1, 1'b0);
        send_word(16'hBEEF, 1'b1, 1'b1);
        send_frame(16'h8000, 1'b1, 16'h7FFF, 1'b0, 1'b1);

        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 66;
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (sub = 0; sub < 3; sub++)
            begin
                idx = mode * 3 + sub;
                poly = (idx == 7) ? 8'($urandom) : POLY_SET[idx];
                // Leave a frame four bytes in so the polynomial changes mid-frame.
                if (idx == 4)
                begin
                    send_word(rand_word(), 1'b1, 1'b1);
                    send_byte(8'($urandom), 1'b0);
                end
                rx_release();
                apply_setting(poly, idx[0]);
                if (idx == 4)
                begin
                    send_byte(8'($urandom), 1'b0);
                    send_byte(8'($urandom), 1'b0);
                    aligned = 1'b1;
                end
                if (mode == 2 && sub == 0)
                begin
                    hold_req = 1'b1;
                end
                while (items_sent < (idx + 1) * ITEM_TARGET / NUM_SETTINGS)
                begin
                    random_sequence();
                end
            end
        end

        rx_release();
        drain();
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sensor_word_crc_frame_checker.f =====
+incdir+sv
sv/scfc_pkg.sv
sv/scfc_ifs.sv
sv/scfc_front.sv
sv/scfc_fifo.sv
sv/scfc_back.sv
sv/sensor_word_crc_frame_checker.sv
dv/scfc_frame_math_pkg.sv
dv/scfc_frame_monitor.sv
dv/tb_sensor_word_crc_frame_checker.sv
